// ----- src/tga_uncompressed_decoder_macros.svh -----
// ============================================================================
// TGA decoder assertion macros
// Shared concurrent assertion forms used by the decoder's checker.
// ============================================================================
`ifndef TGA_UNCOMPRESSED_DECODER_MACROS_SVH
`define TGA_UNCOMPRESSED_DECODER_MACROS_SVH

// Same-cycle implication, disabled while the given reset is high.
`define TGA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while the given reset is high.
`define TGA_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/tgad_pkg.sv -----
// ============================================================================
// TGA decoder package
// Result codes, header layout constants, payload types and small helpers.
// ============================================================================
`timescale 1ns / 1ps

package tgad_pkg;

   // Kind of each result beat.
   typedef enum logic [1:0] {
      KIND_HEADER = 2'd0,
      KIND_PIXEL  = 2'd1,
      KIND_REJECT = 2'd2
   } result_kind_type;

   // Header layout.
   localparam int unsigned HDR_LEN = 18;
   localparam logic [4:0] OFS_IDENT_LEN = 5'd0;
   localparam logic [4:0] OFS_TYPE_LO  = 5'd2;
   localparam logic [4:0] OFS_TYPE_HI  = 5'd3;
   localparam logic [4:0] OFS_CMAP_LO  = 5'd5;
   localparam logic [4:0] OFS_CMAP_HI  = 5'd6;
   localparam logic [4:0] OFS_WIDTH_LO = 5'd12;
   localparam logic [4:0] OFS_WIDTH_HI = 5'd13;
   localparam logic [4:0] OFS_HGT_LO   = 5'd14;
   localparam logic [4:0] OFS_HGT_HI   = 5'd15;
   localparam logic [4:0] OFS_DEPTH    = 5'd16;
   localparam logic [4:0] OFS_DESC     = 5'd17;

   localparam logic [15:0] IMAGE_TYPE_TRUECOLOR = 16'd2;
   localparam logic [7:0]  DESC_INTERLEAVE_MASK = 8'hc0;
   localparam int unsigned DESC_ROWS_UP_BIT     = 5;

   localparam logic [7:0] DEPTH_15 = 8'd15;
   localparam logic [7:0] DEPTH_16 = 8'd16;
   localparam logic [7:0] DEPTH_24 = 8'd24;
   localparam logic [7:0] DEPTH_32 = 8'd32;

   localparam logic [7:0] MAX_VALUE_8BIT = 8'd255;
   localparam logic [7:0] MAX_VALUE_5BIT = 8'h1f;

   // One result beat.
   typedef struct packed {
      result_kind_type result_kind;
      logic [15:0]     image_width;
      logic [15:0]     image_height;
      logic [7:0]      max_value;
      logic [7:0]      red;
      logic [7:0]      green;
      logic [7:0]      blue;
      logic [15:0]     column;
      logic [15:0]     row;
      logic            last;
   } rsp_payload_type;

   // A result offered by the parser to the output buffer.
   typedef struct packed {
      logic            valid;
      rsp_payload_type payload;
   } rsp_push_type;

   function automatic logic depth_supported(input logic [7:0] depth);
      return (depth == DEPTH_15) || (depth == DEPTH_16) ||
             (depth == DEPTH_24) || (depth == DEPTH_32);
   endfunction

   function automatic logic [7:0] max_value_of(input logic [7:0] depth);
      return ((depth == DEPTH_24) || (depth == DEPTH_32)) ? MAX_VALUE_8BIT
                                                          : MAX_VALUE_5BIT;
   endfunction

   // Index of the final byte of a pixel: 3 for 32-bit, 2 for 24-bit, else 1.
   function automatic logic [1:0] pixel_last_index(input logic [7:0] depth);
      logic [1:0] idx;
      idx = 2'd1;
      if (depth == DEPTH_32) idx = 2'd3;
      else if (depth == DEPTH_24) idx = 2'd2;
      return idx;
   endfunction

endpackage

// ----- src/tgad_req_if.sv -----
// ============================================================================
// TGA decoder byte channel
// Valid/ready channel carrying one file byte and its start-of-file flag.
// ============================================================================
`timescale 1ns / 1ps

interface tgad_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       file_start;

   modport source (output valid, output data_byte, output file_start, input ready);
   modport sink   (input valid, input data_byte, input file_start, output ready);
endinterface

// ----- src/tgad_rsp_if.sv -----
// ============================================================================
// TGA decoder result channel
// Valid/ready channel carrying header, pixel and reject results.
// ============================================================================
`timescale 1ns / 1ps

interface tgad_rsp_if import tgad_pkg::*;;
   logic            valid;
   logic            ready;
   result_kind_type result_kind;
   logic [15:0]     image_width;
   logic [15:0]     image_height;
   logic [7:0]      max_value;
   logic [7:0]      red;
   logic [7:0]      green;
   logic [7:0]      blue;
   logic [15:0]     column;
   logic [15:0]     row;
   logic            last;

   modport source (output valid, output result_kind, output image_width,
                   output image_height, output max_value, output red,
                   output green, output blue, output column, output row,
                   output last, input ready);
   modport sink   (input valid, input result_kind, input image_width,
                   input image_height, input max_value, input red,
                   input green, input blue, input column, input row,
                   input last, output ready);
endinterface

// ----- src/tgad_parser.sv -----
// ============================================================================
// TGA decoder stream parser
// Header capture and check, identifier skip and pixel unpacking, one byte
// per accepted beat.
// ============================================================================
`timescale 1ns / 1ps

module tgad_parser import tgad_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  logic [7:0]   data_byte,
   input  logic         file_start,
   output rsp_push_type push
);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_HEADER,
      PH_IDENT,
      PH_PIXELS,
      PH_DONE
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [4:0]  header_count_ff, header_count_in;
   logic [7:0]  ident_len_ff, ident_len_in;
   logic [7:0]  type_lo_ff, type_lo_in;
   logic [7:0]  type_hi_ff, type_hi_in;
   logic [7:0]  cmap_lo_ff, cmap_lo_in;
   logic [7:0]  cmap_hi_ff, cmap_hi_in;
   logic [15:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic [7:0]  depth_ff, depth_in;
   logic [7:0]  desc_ff, desc_in;
   logic [7:0]  ident_remaining_ff, ident_remaining_in;
   logic [1:0]  pix_index_ff, pix_index_in;
   logic [23:0] held_bytes_ff, held_bytes_in;
   logic [15:0] column_ff, column_in;
   logic [15:0] row_ff, row_in;
   logic [15:0] rows_done_ff, rows_done_in;

   phase_type   cur_phase;
   logic [4:0]  cur_count;
   logic        rows_up;
   logic        image_empty;
   logic        header_ok;
   logic        start_pixels;
   logic        col_at_end;
   logic        pix_last;
   logic [15:0] word16;
   logic [7:0]  red_val, green_val, blue_val;

   always_comb begin
      phase_in           = phase_ff;
      header_count_in    = header_count_ff;
      ident_len_in       = ident_len_ff;
      type_lo_in         = type_lo_ff;
      type_hi_in         = type_hi_ff;
      cmap_lo_in         = cmap_lo_ff;
      cmap_hi_in         = cmap_hi_ff;
      width_in           = width_ff;
      height_in          = height_ff;
      depth_in           = depth_ff;
      desc_in            = desc_ff;
      ident_remaining_in = ident_remaining_ff;
      pix_index_in       = pix_index_ff;
      held_bytes_in      = held_bytes_ff;
      column_in          = column_ff;
      row_in             = row_ff;
      rows_done_in       = rows_done_ff;
      push               = '0;
      start_pixels       = 1'b0;

      // A start flag restarts the header with this very byte.
      cur_phase = file_start ? PH_HEADER : phase_ff;
      cur_count = file_start ? 5'd0 : header_count_ff;

      // On the final header byte the descriptor is the incoming byte.
      rows_up = (cur_phase == PH_HEADER) ? data_byte[DESC_ROWS_UP_BIT]
                                         : desc_ff[DESC_ROWS_UP_BIT];
      image_empty = (width_ff == 16'd0) || (height_ff == 16'd0);
      header_ok = ({type_hi_ff, type_lo_ff} == IMAGE_TYPE_TRUECOLOR) &&
                  ((data_byte & DESC_INTERLEAVE_MASK) == 8'd0) &&
                  ({cmap_hi_ff, cmap_lo_ff} == 16'd0) &&
                  depth_supported(depth_ff);

      col_at_end = (column_ff == width_ff - 16'd1);
      pix_last   = col_at_end && (rows_done_ff == height_ff - 16'd1);

      word16 = {data_byte, held_bytes_ff[7:0]};
      if (pixel_last_index(depth_ff) == 2'd1) begin
         red_val   = {3'b000, word16[14:10]};
         green_val = {3'b000, word16[9:5]};
         blue_val  = {3'b000, word16[4:0]};
      end else begin
         blue_val  = held_bytes_ff[7:0];
         green_val = held_bytes_ff[15:8];
         red_val   = (pixel_last_index(depth_ff) == 2'd2) ? data_byte
                                                          : held_bytes_ff[23:16];
      end

      if (accept) begin
         case (cur_phase)
            PH_HEADER: begin
               unique case (cur_count)
                  OFS_IDENT_LEN: ident_len_in       = data_byte;
                  OFS_TYPE_LO:   type_lo_in         = data_byte;
                  OFS_TYPE_HI:   type_hi_in         = data_byte;
                  OFS_CMAP_LO:   cmap_lo_in         = data_byte;
                  OFS_CMAP_HI:   cmap_hi_in         = data_byte;
                  OFS_WIDTH_LO:  width_in[7:0]      = data_byte;
                  OFS_WIDTH_HI:  width_in[15:8]     = data_byte;
                  OFS_HGT_LO:    height_in[7:0]     = data_byte;
                  OFS_HGT_HI:    height_in[15:8]    = data_byte;
                  OFS_DEPTH:     depth_in           = data_byte;
                  OFS_DESC:      desc_in            = data_byte;
                  default:       ident_remaining_in = ident_remaining_ff;
               endcase
               header_count_in = cur_count + 5'd1;
               phase_in        = PH_HEADER;
               if (cur_count == OFS_DESC) begin
                  push.valid = 1'b1;
                  if (!header_ok) begin
                     push.payload.result_kind = KIND_REJECT;
                     phase_in                 = PH_DONE;
                  end else begin
                     push.payload.result_kind  = KIND_HEADER;
                     push.payload.image_width  = width_ff;
                     push.payload.image_height = height_ff;
                     push.payload.max_value    = max_value_of(depth_ff);
                     push.payload.last         = image_empty;
                     ident_remaining_in        = ident_len_ff;
                     if (ident_len_ff != 8'd0) begin
                        phase_in = PH_IDENT;
                     end else begin
                        start_pixels = 1'b1;
                     end
                  end
               end
            end
            PH_IDENT: begin
               ident_remaining_in = ident_remaining_ff - 8'd1;
               if (ident_remaining_ff == 8'd1) begin
                  start_pixels = 1'b1;
               end
            end
            PH_PIXELS: begin
               if (pix_index_ff < pixel_last_index(depth_ff)) begin
                  unique case (pix_index_ff)
                     2'd0:    held_bytes_in[7:0]   = data_byte;
                     2'd1:    held_bytes_in[15:8]  = data_byte;
                     default: held_bytes_in[23:16] = data_byte;
                  endcase
                  pix_index_in = pix_index_ff + 2'd1;
               end else begin
                  push.valid                = 1'b1;
                  push.payload.result_kind  = KIND_PIXEL;
                  push.payload.image_width  = width_ff;
                  push.payload.image_height = height_ff;
                  push.payload.max_value    = max_value_of(depth_ff);
                  push.payload.red          = red_val;
                  push.payload.green        = green_val;
                  push.payload.blue         = blue_val;
                  push.payload.column       = column_ff;
                  push.payload.row          = row_ff;
                  push.payload.last         = pix_last;
                  pix_index_in              = 2'd0;
                  if (pix_last) begin
                     phase_in = PH_DONE;
                  end else if (col_at_end) begin
                     column_in    = 16'd0;
                     rows_done_in = rows_done_ff + 16'd1;
                     row_in       = desc_ff[DESC_ROWS_UP_BIT] ? row_ff + 16'd1
                                                              : row_ff - 16'd1;
                  end else begin
                     column_in = column_ff + 16'd1;
                  end
               end
            end
            default: begin
               phase_in = cur_phase;
            end
         endcase

         if (start_pixels) begin
            pix_index_in = 2'd0;
            column_in    = 16'd0;
            rows_done_in = 16'd0;
            row_in       = rows_up ? 16'd0 : height_ff - 16'd1;
            phase_in     = image_empty ? PH_DONE : PH_PIXELS;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= PH_IDLE;
         header_count_ff    <= 5'd0;
         ident_remaining_ff <= 8'd0;
         pix_index_ff       <= 2'd0;
         column_ff          <= 16'd0;
         row_ff             <= 16'd0;
         rows_done_ff       <= 16'd0;
      end else begin
         phase_ff           <= phase_in;
         header_count_ff    <= header_count_in;
         ident_remaining_ff <= ident_remaining_in;
         pix_index_ff       <= pix_index_in;
         column_ff          <= column_in;
         row_ff             <= row_in;
         rows_done_ff       <= rows_done_in;
      end
   end

   // Header bytes and pixel byte holding are payload and need no reset.
   always_ff @(posedge clock) begin
      ident_len_ff  <= ident_len_in;
      type_lo_ff    <= type_lo_in;
      type_hi_ff    <= type_hi_in;
      cmap_lo_ff    <= cmap_lo_in;
      cmap_hi_ff    <= cmap_hi_in;
      width_ff      <= width_in;
      height_ff     <= height_in;
      depth_ff      <= depth_in;
      desc_ff       <= desc_in;
      held_bytes_ff <= held_bytes_in;
   end

endmodule

// ----- src/tgad_out_buf.sv -----
// ============================================================================
// TGA decoder output buffer
// Result register with a skid entry behind it, so a stalled result does not
// stop the byte channel at once.
// ============================================================================
`timescale 1ns / 1ps

module tgad_out_buf import tgad_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  rsp_push_type    push,
   output logic            can_take,
   output logic            out_valid,
   output rsp_payload_type out_data,
   input  logic            out_ready
);

   logic            main_valid_ff, main_valid_in;
   logic            skid_valid_ff, skid_valid_in;
   rsp_payload_type main_data_ff, main_data_in;
   rsp_payload_type skid_data_ff, skid_data_in;
   logic            pop;

   assign can_take  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;
   assign pop       = main_valid_ff && out_ready;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_data_in  = main_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         // No push can arrive while the skid entry is full.
         if (pop) begin
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!main_valid_ff || pop) begin
         main_valid_in = push.valid;
         main_data_in  = push.payload;
      end else if (push.valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push.payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

// ----- src/tga_uncompressed_decoder.sv -----
// ============================================================================
// Uncompressed true-color TGA decoder
// Parses a TGA byte stream and emits header, pixel and reject results.
// ============================================================================
// The decoder takes one file byte per beat on req_chan, with file_start
// marking the first byte of a file; a start flag at any point abandons the
// current file. It collects the 18-byte header and emits one header result
// when the file is accepted (type word 2, no interleave bits, no colormap,
// depth 15, 16, 24 or 32) or one reject result otherwise. Identifier bytes
// are skipped, then every 2, 3 or 4 input bytes produce one pixel result on
// rsp_chan with its column and row; rows count down from height minus one
// unless descriptor bit 5 is set, and the alpha byte of 32-bit pixels is
// dropped. Bytes outside an open file, after a reject or after the last
// pixel produce nothing. The parser does all its work in a single pass
// between its state registers and the result register, so the block
// sustains one byte per cycle while req_chan.ready is high; a result is
// registered in the result register, or in the skid entry while that one
// is held. Behind the result register sits one skid entry; req_chan.ready
// drops only while both are full, and is low during reset.
`timescale 1ns / 1ps

module tga_uncompressed_decoder import tgad_pkg::*; (
   input logic        clock,
   input logic        reset,
   tgad_req_if.sink   req_chan,
   tgad_rsp_if.source rsp_chan
);

   rsp_push_type    push;
   rsp_payload_type out_data;
   logic            can_take;
   logic            accept;

   assign req_chan.ready = can_take && !reset;
   assign accept         = req_chan.valid && req_chan.ready;

   // Byte parser: header, identifier skip and pixel unpacking.
   tgad_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_byte  (req_chan.data_byte),
      .file_start (req_chan.file_start),
      .push       (push)
   );

   // Result register and skid entry.
   tgad_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .can_take  (can_take),
      .out_valid (rsp_chan.valid),
      .out_data  (out_data),
      .out_ready (rsp_chan.ready)
   );

   assign rsp_chan.result_kind  = out_data.result_kind;
   assign rsp_chan.image_width  = out_data.image_width;
   assign rsp_chan.image_height = out_data.image_height;
   assign rsp_chan.max_value    = out_data.max_value;
   assign rsp_chan.red          = out_data.red;
   assign rsp_chan.green        = out_data.green;
   assign rsp_chan.blue         = out_data.blue;
   assign rsp_chan.column       = out_data.column;
   assign rsp_chan.row          = out_data.row;
   assign rsp_chan.last         = out_data.last;

endmodule

// ----- src/tgad_checker.sv -----
// ============================================================================
// TGA decoder port checker
// Checks on the decoder's channel ports over time, bound to the top level.
// ============================================================================
`timescale 1ns / 1ps
`include "tga_uncompressed_decoder_macros.svh"

module tgad_checker import tgad_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input result_kind_type rsp_kind,
   input logic [15:0]     rsp_width,
   input logic [15:0]     rsp_height,
   input logic [15:0]     rsp_column,
   input logic            rsp_last
);

   // Nothing is offered in the cycle after a reset.
   `TGA_ASSERT_NXT(a_reset_clears, clock, 1'b0, reset, !rsp_valid, "result after reset")

   // A stalled result stays offered.
   `TGA_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result dropped")

   // A result only appears after a byte was taken.
   `TGA_ASSERT_IMP(a_rsp_cause, clock, reset, $rose(rsp_valid), $past(req_valid && req_ready), "result without byte")

   // The final pixel sits in the last column.
   `TGA_ASSERT_IMP(a_last_column, clock, reset, rsp_valid && rsp_kind == KIND_PIXEL && rsp_last, rsp_column == rsp_width - 16'd1, "last pixel off column")

   // A header is marked last exactly when the image is empty.
   `TGA_ASSERT_IMP(a_header_last, clock, reset, rsp_valid && rsp_kind == KIND_HEADER, rsp_last == (rsp_width == 16'd0 || rsp_height == 16'd0), "header last mismatch")

endmodule

bind tga_uncompressed_decoder tgad_checker u_tgad_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_kind   (rsp_chan.result_kind),
   .rsp_width  (rsp_chan.image_width),
   .rsp_height (rsp_chan.image_height),
   .rsp_column (rsp_chan.column),
   .rsp_last   (rsp_chan.last)
);

// ----- sim/tga_decode_checker.sv -----
// ============================================================================
// TGA decoder result checker
// Watches the byte and result channels, predicts every result beat from the
// accepted bytes and compares each delivered beat field by field.
// ============================================================================
`timescale 1ns / 1ps

module tga_decode_checker import tgad_pkg::*; (
   input logic  clock,
   input logic  reset,
   tgad_req_if  byte_bus,
   tgad_rsp_if  result_bus,
   output int   fail_count,
   output int   outstanding
);

   typedef enum logic [2:0] {
      STAGE_IDLE,
      STAGE_HEADER,
      STAGE_IDENT,
      STAGE_PIXELS,
      STAGE_DONE
   } decode_stage_type;

   decode_stage_type stage;
   logic [4:0]       hdr_count;
   logic [7:0]       hdr_bytes [HDR_LEN];
   logic [7:0]       ident_left;
   logic [1:0]       byte_index;
   logic [23:0]      held;
   logic [15:0]      col_pos;
   logic [15:0]      row_pos;
   logic [15:0]      rows_done;

   rsp_payload_type  pending_results [$];

   function automatic logic [15:0] hdr_word(input int at);
      return {hdr_bytes[at + 1], hdr_bytes[at]};
   endfunction

   function automatic logic [7:0] full_scale();
      return (hdr_bytes[OFS_DEPTH] == DEPTH_24 || hdr_bytes[OFS_DEPTH] == DEPTH_32)
             ? MAX_VALUE_8BIT : MAX_VALUE_5BIT;
   endfunction

   task automatic reset_decoder();
      stage = STAGE_IDLE;
      hdr_count = '0;
      foreach (hdr_bytes[i]) hdr_bytes[i] = '0;
      ident_left = '0;
      byte_index = '0;
      held = '0;
      col_pos = '0;
      row_pos = '0;
      rows_done = '0;
   endtask

   task automatic start_pixels();
      logic [15:0] w;
      logic [15:0] h;
      w = hdr_word(OFS_WIDTH_LO);
      h = hdr_word(OFS_HGT_LO);
      byte_index = '0;
      held = '0;
      col_pos = '0;
      rows_done = '0;
      row_pos = hdr_bytes[OFS_DESC][DESC_ROWS_UP_BIT] ? 16'd0 : h - 16'd1;
      stage = (w == 16'd0 || h == 16'd0) ? STAGE_DONE : STAGE_PIXELS;
   endtask

   task automatic close_header(output rsp_payload_type res);
      logic [7:0]  depth;
      logic [15:0] w;
      logic [15:0] h;
      logic        accepted;
      depth = hdr_bytes[OFS_DEPTH];
      w = hdr_word(OFS_WIDTH_LO);
      h = hdr_word(OFS_HGT_LO);
      accepted = hdr_word(OFS_TYPE_LO) == IMAGE_TYPE_TRUECOLOR
                 && (hdr_bytes[OFS_DESC] & DESC_INTERLEAVE_MASK) == 8'd0
                 && hdr_word(OFS_CMAP_LO) == 16'd0
                 && (depth == DEPTH_15 || depth == DEPTH_16 ||
                     depth == DEPTH_24 || depth == DEPTH_32);
      res = '0;
      if (!accepted) begin
         res.result_kind = KIND_REJECT;
         stage = STAGE_DONE;
      end else begin
         res.result_kind = KIND_HEADER;
         res.image_width = w;
         res.image_height = h;
         res.max_value = full_scale();
         res.last = (w == 16'd0 || h == 16'd0);
         ident_left = hdr_bytes[OFS_IDENT_LEN];
         if (ident_left != 8'd0) stage = STAGE_IDENT;
         else start_pixels();
      end
   endtask

   task automatic pixel_byte(input logic [7:0] b, output logic produced,
                             output rsp_payload_type res);
      logic [7:0]  depth;
      logic [1:0]  final_idx;
      logic [15:0] w;
      logic [15:0] h;
      logic [15:0] word;
      logic        at_end;
      depth = hdr_bytes[OFS_DEPTH];
      final_idx = (depth == DEPTH_32) ? 2'd3 : (depth == DEPTH_24) ? 2'd2 : 2'd1;
      w = hdr_word(OFS_WIDTH_LO);
      h = hdr_word(OFS_HGT_LO);
      res = '0;
      produced = 1'b0;
      if (byte_index < final_idx) begin
         held[8 * byte_index +: 8] = b;
         byte_index = byte_index + 2'd1;
      end else begin
         // A 5-5-5 word drops its top bit; a 32-bit pixel drops its alpha byte.
         produced = 1'b1;
         if (final_idx == 2'd1) begin
            word = {b, held[7:0]};
            res.red = {3'b000, word[14:10]};
            res.green = {3'b000, word[9:5]};
            res.blue = {3'b000, word[4:0]};
         end else begin
            if (final_idx == 2'd2) held[23:16] = b;
            res.blue = held[7:0];
            res.green = held[15:8];
            res.red = held[23:16];
         end
         at_end = (col_pos == w - 16'd1) && (rows_done == h - 16'd1);
         res.result_kind = KIND_PIXEL;
         res.image_width = w;
         res.image_height = h;
         res.max_value = full_scale();
         res.column = col_pos;
         res.row = row_pos;
         res.last = at_end;
         byte_index = '0;
         held = '0;
         if (at_end) begin
            stage = STAGE_DONE;
         end else if (col_pos == w - 16'd1) begin
            col_pos = '0;
            rows_done = rows_done + 16'd1;
            row_pos = hdr_bytes[OFS_DESC][DESC_ROWS_UP_BIT] ? row_pos + 16'd1
                                                            : row_pos - 16'd1;
         end else begin
            col_pos = col_pos + 16'd1;
         end
      end
   endtask

   task automatic decode_byte(input logic [7:0] b, input logic start,
                              output logic produced, output rsp_payload_type res);
      res = '0;
      produced = 1'b0;
      if (start) begin
         stage = STAGE_HEADER;
         hdr_count = '0;
      end
      case (stage)
         STAGE_HEADER: begin
            hdr_bytes[hdr_count] = b;
            hdr_count = hdr_count + 5'd1;
            if (hdr_count == HDR_LEN) begin
               produced = 1'b1;
               close_header(res);
            end
         end
         STAGE_IDENT: begin
            ident_left = ident_left - 8'd1;
            if (ident_left == 8'd0) start_pixels();
         end
         STAGE_PIXELS: pixel_byte(b, produced, res);
         default: ;
      endcase
   endtask

   task automatic report_error(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      fail_count++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want)
         report_error($sformatf("%s is %0h, expected %0h", name, got, want));
   endtask

   task automatic compare_result(input rsp_payload_type want);
      check_field("result_kind", result_bus.result_kind, want.result_kind);
      check_field("image_width", result_bus.image_width, want.image_width);
      check_field("image_height", result_bus.image_height, want.image_height);
      check_field("max_value", result_bus.max_value, want.max_value);
      check_field("red", result_bus.red, want.red);
      check_field("green", result_bus.green, want.green);
      check_field("blue", result_bus.blue, want.blue);
      check_field("column", result_bus.column, want.column);
      check_field("row", result_bus.row, want.row);
      check_field("last", result_bus.last, want.last);
   endtask

   always @(posedge clock) begin
      logic            produced;
      rsp_payload_type predicted;
      if (reset) begin
         reset_decoder();
         pending_results.delete();
         fail_count = 0;
      end else begin
         if (byte_bus.valid && byte_bus.ready) begin
            decode_byte(byte_bus.data_byte, byte_bus.file_start, produced, predicted);
            if (produced) pending_results.push_back(predicted);
         end
         if (result_bus.valid && result_bus.ready) begin
            if (pending_results.size() == 0) begin
               report_error("result beat arrived with none predicted");
            end else begin
               compare_result(pending_results[0]);
               void'(pending_results.pop_front());
            end
         end
      end
      outstanding = pending_results.size();
   end

endmodule

// ----- sim/tga_uncompressed_decoder_test.sv -----
// ============================================================================
// TGA decoder testbench
// Streams directed and random TGA files into the decoder under random
// backpressure while a checker predicts and compares every result beat.
// ============================================================================
`timescale 1ns / 1ps

module tga_uncompressed_decoder_test;
   import tgad_pkg::*;

   // Random part length, counted in file beats sent; stray bytes are not counted.
   localparam int RANDOM_BEATS = 180;
   // The final stretch of the random part runs with no idling on either side.
   localparam int QUIET_BEATS = 50;
   // The long receiver hold-off is far longer than the result register plus
   // its skid entry can absorb, so the byte channel must stall behind it.
   localparam int LONG_HOLD_CYCLES = 250;
   // This margin covers the result register behind each byte and lets any
   // stray extra beat show up before the verdict.
   localparam int DRAIN_CYCLES = 20;
   // The slowest legal run is roughly 900 beats, each with the longest sender
   // gap and the longest receiver stall, plus the long hold-off. The limit is
   // several times that.
   localparam int CYCLE_LIMIT = 300000;

   logic clock = 1'b0;
   logic reset;

   tgad_req_if req_chan ();
   tgad_rsp_if rsp_chan ();

   int         fail_count;
   int         outstanding;
   int         cycle_count = 0;
   int         file_beats = 0;
   int         beat_goal;
   bit         quiet = 1'b0;
   bit         no_gaps = 1'b0;
   bit         long_hold = 1'b0;
   logic [7:0] file_bytes [$];

   always #5 clock = ~clock;

   tga_uncompressed_decoder uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   tga_decode_checker checker_inst (
      .clock       (clock),
      .reset       (reset),
      .byte_bus    (req_chan),
      .result_bus  (rsp_chan),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // Offer one byte and hold it until the decoder takes it. The ready sampled
   // here is the value from before the edge, so valid and ready both high at
   // that edge means the beat was accepted. Valid is left high so that a
   // back-to-back beat needs no second assignment in the same step.
   task automatic send_beat(input logic [7:0] b, input logic start);
      req_chan.valid <= 1'b1;
      req_chan.data_byte <= b;
      req_chan.file_start <= start;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // Occasional random sender gap, except in the quiet stretch and
   // while the receiver hold-off needs a steady stream of beats.
   task automatic maybe_idle();
      if (!quiet && !no_gaps && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   // Stop offering beats until every predicted result has been delivered.
   // The extra edge lets the checker record the last accepted beat first.
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      wait (outstanding == 0);
   endtask

   // Assemble one file: an 18-byte header with random filler in the fields
   // the decoder does not check, then the identifier, the pixel bytes that
   // the header calls for, and any trailing bytes.
   task automatic build_file(input logic [7:0] ident_len, input logic [15:0] type_word,
                             input logic [15:0] cmap_len, input logic [15:0] width,
                             input logic [15:0] height, input logic [7:0] depth,
                             input logic [7:0] desc, input int trailing);
      int bpp;
      int body;
      bpp = (depth == DEPTH_32) ? 4 : (depth == DEPTH_24) ? 3 : 2;
      body = int'(ident_len) + int'(width) * int'(height) * bpp + trailing;
      file_bytes.delete();
      repeat (HDR_LEN) file_bytes.push_back(8'($urandom));
      file_bytes[OFS_IDENT_LEN] = ident_len;
      file_bytes[OFS_TYPE_LO] = type_word[7:0];
      file_bytes[OFS_TYPE_HI] = type_word[15:8];
      file_bytes[OFS_CMAP_LO] = cmap_len[7:0];
      file_bytes[OFS_CMAP_HI] = cmap_len[15:8];
      file_bytes[OFS_WIDTH_LO] = width[7:0];
      file_bytes[OFS_WIDTH_HI] = width[15:8];
      file_bytes[OFS_HGT_LO] = height[7:0];
      file_bytes[OFS_HGT_HI] = height[15:8];
      file_bytes[OFS_DEPTH] = depth;
      file_bytes[OFS_DESC] = desc;
      repeat (body) file_bytes.push_back(8'($urandom));
   endtask

   // Send the first count bytes of the assembled file, flagging the first
   // one as the start of a file. A short count leaves the file unfinished.
   task automatic send_file_bytes(input int count);
      for (int i = 0; i < count; i++) begin
         send_beat(file_bytes[i], i == 0);
         file_beats++;
         maybe_idle();
      end
   endtask

   // One random file. Most are well formed with small images so that the
   // pixel path gets most of the beats; some are rejected by one failing
   // header check, some are cut short by the next file's start, and some
   // are preceded by stray bytes that carry no start flag.
   task automatic random_file();
      logic [15:0] w;
      logic [15:0] h;
      logic [15:0] type_word;
      logic [15:0] cmap;
      logic [7:0]  depth;
      logic [7:0]  desc;
      logic [7:0]  ident;
      int          shape;
      int          trailing;
      shape = $urandom_range(0, 15);
      case ($urandom_range(0, 3))
         0: depth = DEPTH_15;
         1: depth = DEPTH_16;
         2: depth = DEPTH_24;
         default: depth = DEPTH_32;
      endcase
      w = 16'($urandom_range(1, 4));
      h = 16'($urandom_range(1, 3));
      // Now and then an empty image with the other dimension anywhere.
      if ($urandom_range(0, 11) == 0) begin
         if ($urandom_range(0, 1) == 1) begin
            w = 16'd0;
            h = 16'($urandom);
         end else begin
            h = 16'd0;
            w = 16'($urandom);
         end
      end
      desc = 8'($urandom_range(0, 63));
      ident = ($urandom_range(0, 29) == 0) ? 8'($urandom_range(128, 255))
                                           : 8'($urandom_range(0, 3));
      type_word = IMAGE_TYPE_TRUECOLOR;
      cmap = 16'd0;
      trailing = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      if (shape < 3) begin
         case ($urandom_range(0, 3))
            0: type_word = 16'($urandom);
            1: desc = desc | (8'($urandom_range(1, 3)) << 6);
            2: cmap = 16'($urandom_range(1, 65535));
            default: depth = 8'($urandom);
         endcase
      end
      if ($urandom_range(0, 7) == 0) begin
         repeat ($urandom_range(1, 3)) begin
            send_beat(8'($urandom), 1'b0);
            maybe_idle();
         end
      end
      build_file(ident, type_word, cmap, w, h, depth, desc, trailing);
      if (shape == 3) send_file_bytes($urandom_range(1, file_bytes.size() - 1));
      else send_file_bytes(file_bytes.size());
   endtask

   // Receiver: mostly ready, with random stall bursts, one long hold-off on
   // request, and no stalls at all in the quiet stretch.
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            long_hold = 1'b0;
         end else if (quiet || $urandom_range(0, 3) != 0) begin
            rsp_chan.ready <= 1'b1;
         end else begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 16) - 1) @(posedge clock);
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL tga_uncompressed_decoder");
      $finish;
   end

   initial begin
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.data_byte <= 8'd0;
      req_chan.file_start <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Bytes before any file has started are ignored.
      send_beat(8'h00, 1'b0);
      send_beat(8'hff, 1'b0);
      send_beat(8'h5a, 1'b0);

      // 32-bit pixel with an identifier to skip and a trailing byte; the
      // alpha byte must be dropped.
      build_file(8'd2, IMAGE_TYPE_TRUECOLOR, 16'd0, 16'd1, 16'd1, DEPTH_32, 8'h00, 1);
      send_file_bytes(file_bytes.size());

      // 24-bit 2x2 image with rows counting up.
      build_file(8'd0, IMAGE_TYPE_TRUECOLOR, 16'd0, 16'd2, 16'd2, DEPTH_24, 8'h20, 0);
      send_file_bytes(file_bytes.size());

      // 16-bit 1x2 image counting down, with all-ones and all-zero words so
      // that the ignored top bit is exercised.
      build_file(8'd0, IMAGE_TYPE_TRUECOLOR, 16'd0, 16'd1, 16'd2, DEPTH_16, 8'h1f, 0);
      file_bytes[HDR_LEN] = 8'hff;
      file_bytes[HDR_LEN + 1] = 8'hff;
      file_bytes[HDR_LEN + 2] = 8'h00;
      file_bytes[HDR_LEN + 3] = 8'h00;
      send_file_bytes(file_bytes.size());

      // Empty images at the extreme dimensions: the header carries last and
      // the trailing bytes are ignored.
      build_file(8'd0, IMAGE_TYPE_TRUECOLOR, 16'd0, 16'd0, 16'hffff, DEPTH_15, 8'h00, 2);
      send_file_bytes(file_bytes.size());
      build_file(8'd0, IMAGE_TYPE_TRUECOLOR, 16'd0, 16'hffff, 16'd0, DEPTH_24, 8'h3f, 0);
      send_file_bytes(file_bytes.size());

      // Each header check failing on its own; the rest of the file is
      // ignored after the reject beat.
      build_file(8'd0, 16'h0003, 16'd0, 16'd1, 16'd1, DEPTH_24, 8'h00, 1);
      send_file_bytes(file_bytes.size());
      build_file(8'd0, 16'h0102, 16'd0, 16'd1, 16'd1, DEPTH_24, 8'h00, 0);
      send_file_bytes(file_bytes.size());
      build_file(8'd0, IMAGE_TYPE_TRUECOLOR, 16'd0, 16'd1, 16'd1, DEPTH_16, 8'h80, 0);
      send_file_bytes(file_bytes.size());
      build_file(8'd0, IMAGE_TYPE_TRUECOLOR, 16'd0, 16'd1, 16'd1, DEPTH_16, 8'h40, 0);
      send_file_bytes(file_bytes.size());
      build_file(8'd0, IMAGE_TYPE_TRUECOLOR, 16'h0100, 16'd1, 16'd1, DEPTH_32, 8'h00, 0);
      send_file_bytes(file_bytes.size());
      build_file(8'd0, IMAGE_TYPE_TRUECOLOR, 16'd0, 16'd1, 16'd1, 8'd8, 8'h00, 0);
      send_file_bytes(file_bytes.size());

      // A new start abandons a file in its header and again in its pixels.
      build_file(8'd0, IMAGE_TYPE_TRUECOLOR, 16'd0, 16'd2, 16'd2, DEPTH_16, 8'h00, 0);
      send_file_bytes(10);
      send_file_bytes(HDR_LEN + 3);
      build_file(8'd0, IMAGE_TYPE_TRUECOLOR, 16'd0, 16'd1, 16'd1, DEPTH_32, 8'h20, 0);
      send_file_bytes(file_bytes.size());
      drain_results();

      // Receiver hold-off while the sender streams a 16-pixel file without
      // gaps: the result register and skid entry fill and the byte channel
      // stalls until the hold-off ends.
      beat_goal = file_beats + RANDOM_BEATS;
      long_hold = 1'b1;
      no_gaps = 1'b1;
      build_file(8'd0, IMAGE_TYPE_TRUECOLOR, 16'd0, 16'd4, 16'd4, DEPTH_24, 8'h00, 0);
      send_file_bytes(file_bytes.size());
      no_gaps = 1'b0;
      drain_results();

      while (file_beats < beat_goal) begin
         if (file_beats > beat_goal - QUIET_BEATS) quiet = 1'b1;
         random_file();
         if (!quiet && $urandom_range(0, 7) == 0) drain_results();
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("PASS tga_uncompressed_decoder");
      end else begin
         $display("FAIL tga_uncompressed_decoder");
      end
      $finish;
   end

endmodule
